// ===== rtl/sssp_pkg.sv =====
`default_nettype none
package sssp_pkg;

  // Build-time defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 256;
  localparam int MAX_EDGES_DEF    = 1024;

  // Fixed field widths
  localparam int KIND_W     = 2;
  localparam int VID_W      = 8;
  localparam int DIST_W     = 32;
  localparam int VCOUNT_W   = 9;
  localparam int PASS_OUT_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  // Command codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_VERTEX  = 1'd1;

  // Outcome of testing one edge
  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] alt;
  } relax_t;

endpackage
`default_nettype wire

// ===== rtl/sssp_in_if.sv =====
`default_nettype none
interface sssp_in_if;
  import sssp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [VID_W-1:0]  edge_source;
  logic [VID_W-1:0]  edge_dest;
  logic [DIST_W-1:0] edge_weight;
  logic [VID_W-1:0]  query_vertex;

  modport source (output valid, kind, edge_source, edge_dest, edge_weight, query_vertex,
                  input ready);
  modport sink   (input valid, kind, edge_source, edge_dest, edge_weight, query_vertex,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/sssp_out_if.sv =====
`default_nettype none
interface sssp_out_if;
  import sssp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  negative_cycle;
  logic                  edge_overflow;
  logic [PASS_OUT_W-1:0] passes_used;
  logic [VID_W-1:0]      vertex_echo;
  logic                  reachable;
  logic [DIST_W-1:0]     distance;
  logic                  has_parent;
  logic [VID_W-1:0]      parent_vertex;

  modport source (output valid, negative_cycle, edge_overflow, passes_used, vertex_echo,
                         reachable, distance, has_parent, parent_vertex,
                  input ready);
  modport sink   (input valid, negative_cycle, edge_overflow, passes_used, vertex_echo,
                        reachable, distance, has_parent, parent_vertex,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/single_source_shortest_path_core.sv =====
`default_nettype none
// Channel   Dir  Handshake      Contents
// in_chan   in   valid/ready    kind, edge endpoints and weight, query vertex
// out_chan  out  valid/ready    run summary or query answer (one beat per run/query)
// cfg_*     in   cfg_we only    vertex count (index 0), root vertex (index 1)
//
// Add-edge and clear beats are taken while idle; a query waits for a free output slot.
// A run first rewrites all MAX_VERTICES entries of the distance memory, then handles
// each stored edge in turn (edge read, two distance reads, compare and write back)
// for up to vertex_count-1 relaxation passes plus one check pass.
// Reset is synchronous; distances read as unreachable until the first run.
// in_chan.ready is high only while idle; a held output beat stalls query/run completion.
module single_source_shortest_path_core #(
  parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = sssp_pkg::MAX_EDGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sssp_in_if.sink                          in_chan,
  sssp_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [sssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sssp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sssp_pkg::*;

  localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EDW = 2 * VID_W + DIST_W;     // edge word {weight, dest, source}
  localparam int DMW = 1 + VID_W + DIST_W;     // distance word {parent valid, parent, dist}

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SWEEP = 8'b0000_0010,
    S_PASS  = 8'b0000_0100,
    S_EDGE  = 8'b0000_1000,
    S_ELD   = 8'b0001_0000,
    S_CALC  = 8'b0010_0000,
    S_RES   = 8'b0100_0000,
    S_QRY   = 8'b1000_0000
  } state_t;

  function automatic logic [VAW-1:0] to_vaddr(input logic [VID_W-1:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[VAW-1:0];
  endfunction

  // Memories
  logic [EDW-1:0] edge_mem [MAX_EDGES];
  logic [DMW-1:0] dist_mem [MAX_VERTICES];

  // Control and config state
  state_t               state_r, state_nxt;
  logic [VCOUNT_W-1:0]  vcount_r;
  logic [VID_W-1:0]     start_r;
  logic [ECW-1:0]       edge_total_r;
  logic                 ovf_r;
  logic                 ran_r;
  logic [VAW-1:0]       sweep_r;
  logic [ECW-1:0]       edge_idx_r;
  logic [VCOUNT_W-1:0]  passes_r;
  logic                 changed_r;
  logic                 check_r;
  logic                 neg_r;
  logic [VID_W-1:0]     q_vertex_r;
  logic                 q_inrange_r;

  // Memory read registers
  logic [EDW-1:0] edge_rd_r;
  logic [DMW-1:0] rd_a_r;
  logic [DMW-1:0] rd_b_r;

  // Output register
  logic                  out_valid_r;
  logic                  o_neg_r;
  logic                  o_ovf_r;
  logic [PASS_OUT_W-1:0] o_passes_r;
  logic [VID_W-1:0]      o_vecho_r;
  logic                  o_reach_r;
  logic [DIST_W-1:0]     o_dist_r;
  logic                  o_hp_r;
  logic [VID_W-1:0]      o_par_r;

  // Active vertex count, clamped to 1..MAX_VERTICES
  logic [VCOUNT_W-1:0] n_eff;
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = VCOUNT_W'(1);
    end else if (32'(vcount_r) > 32'(MAX_VERTICES)) begin
      n_eff = VCOUNT_W'(MAX_VERTICES);
    end else begin
      n_eff = vcount_r;
    end
  end

  logic start_ok;
  assign start_ok = {1'b0, start_r} < n_eff;

  // Input beat decode
  logic acc, acc_add, acc_run, acc_qry, acc_clr, store_full;
  assign in_chan.ready = (state_r == S_IDLE);
  assign acc        = in_chan.valid && in_chan.ready;
  assign acc_add    = acc && (in_chan.kind == KIND_ADD);
  assign acc_run    = acc && (in_chan.kind == KIND_RUN);
  assign acc_qry    = acc && (in_chan.kind == KIND_QUERY);
  assign acc_clr    = acc && (in_chan.kind == KIND_CLEAR);
  assign store_full = edge_total_r >= ECW'(MAX_EDGES);

  // Current edge fields
  logic [VID_W-1:0]  e_u, e_v;
  logic [DIST_W-1:0] e_w;
  assign e_u = edge_rd_r[VID_W-1:0];
  assign e_v = edge_rd_r[2*VID_W-1:VID_W];
  assign e_w = edge_rd_r[EDW-1:2*VID_W];

  // Relaxation test on the two distance reads
  relax_t relax;
  sssp_relax u_relax (
    .u   (e_u),
    .v   (e_v),
    .n   (n_eff),
    .du  (rd_a_r[DIST_W-1:0]),
    .dv  (rd_b_r[DIST_W-1:0]),
    .w   (e_w),
    .res (relax)
  );

  // Loop control
  logic sweep_last, sweep_is_start, edges_done, more_passes, slot_free;
  assign sweep_last     = sweep_r == VAW'(MAX_VERTICES - 1);
  assign sweep_is_start = start_ok && (32'(start_r) == 32'(sweep_r));
  assign edges_done     = edge_idx_r == edge_total_r;
  assign more_passes    = changed_r && (({1'b0, passes_r} + 10'd1) < {1'b0, n_eff});
  assign slot_free      = !out_valid_r || out_chan.ready;

  // Distance memory ports
  logic           d_we, d_rea, d_reb;
  logic [VAW-1:0] d_waddr, d_raddr_a, d_raddr_b;
  logic [DMW-1:0] d_wdata;
  always_comb begin
    d_we      = 1'b0;
    d_waddr   = sweep_r;
    d_wdata   = {1'b0, {VID_W{1'b0}}, sweep_is_start ? {DIST_W{1'b0}} : DIST_INF};
    d_rea     = 1'b0;
    d_reb     = 1'b0;
    d_raddr_a = to_vaddr(e_u);
    d_raddr_b = to_vaddr(e_v);
    if (state_r == S_SWEEP) begin
      d_we = 1'b1;
    end else if (state_r == S_CALC && relax.hit && !check_r) begin
      d_we    = 1'b1;
      d_waddr = to_vaddr(e_v);
      d_wdata = {1'b1, e_u, relax.alt};
    end
    if (state_r == S_ELD) begin
      d_rea = 1'b1;
      d_reb = 1'b1;
    end else if (acc_qry) begin
      d_rea     = 1'b1;
      d_raddr_a = to_vaddr(in_chan.query_vertex);
    end
  end

  // Distance memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (d_we) begin
      dist_mem[d_waddr] <= d_wdata;
    end
    if (d_rea) begin
      rd_a_r <= dist_mem[d_raddr_a];
    end
    if (d_reb) begin
      rd_b_r <= dist_mem[d_raddr_b];
    end
  end

  // Edge memory: written on add beats, read during passes
  always_ff @(posedge clk) begin
    if (acc_add && !store_full) begin
      edge_mem[edge_total_r[EAW-1:0]] <= {in_chan.edge_weight, in_chan.edge_dest,
                                          in_chan.edge_source};
    end
    if (state_r == S_EDGE && !edges_done) begin
      edge_rd_r <= edge_mem[edge_idx_r[EAW-1:0]];
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_run) begin
          state_nxt = S_SWEEP;
        end else if (acc_qry) begin
          state_nxt = S_QRY;
        end
      end
      S_SWEEP: if (sweep_last) state_nxt = S_PASS;
      S_PASS:  state_nxt = S_EDGE;
      S_EDGE: begin
        if (!edges_done) begin
          state_nxt = S_ELD;
        end else if (check_r) begin
          state_nxt = S_RES;
        end else begin
          state_nxt = S_PASS;
        end
      end
      S_ELD:  state_nxt = S_CALC;
      S_CALC: state_nxt = (relax.hit && check_r) ? S_RES : S_EDGE;
      S_RES:  if (slot_free) state_nxt = S_IDLE;
      S_QRY:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vcount_r     <= VCOUNT_W'(256);
      start_r      <= '0;
      edge_total_r <= '0;
      ovf_r        <= 1'b0;
      ran_r        <= 1'b0;
      sweep_r      <= '0;
      edge_idx_r   <= '0;
      passes_r     <= '0;
      changed_r    <= 1'b0;
      check_r      <= 1'b0;
      neg_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VERTEX_COUNT: vcount_r <= cfg_wdata[VCOUNT_W-1:0];
          CFG_ROOT_VERTEX:  start_r  <= cfg_wdata[VID_W-1:0];
          default: ;
        endcase
      end

      // Edge list bookkeeping
      if (acc_add) begin
        if (store_full) begin
          ovf_r <= 1'b1;
        end else begin
          edge_total_r <= edge_total_r + ECW'(1);
        end
      end
      if (acc_clr) begin
        edge_total_r <= '0;
        ovf_r        <= 1'b0;
      end

      // Run sequencing
      if (acc_run) begin
        ran_r     <= 1'b1;
        sweep_r   <= '0;
        passes_r  <= '0;
        changed_r <= 1'b1;
        check_r   <= 1'b0;
        neg_r     <= 1'b0;
      end
      if (state_r == S_SWEEP) begin
        sweep_r <= sweep_r + VAW'(1);
      end
      if (state_r == S_PASS) begin
        edge_idx_r <= '0;
        if (more_passes) begin
          passes_r  <= passes_r + VCOUNT_W'(1);
          changed_r <= 1'b0;
        end else begin
          check_r <= 1'b1;
        end
      end
      if (state_r == S_CALC) begin
        edge_idx_r <= edge_idx_r + ECW'(1);
        if (relax.hit) begin
          if (check_r) begin
            neg_r <= 1'b1;
          end else begin
            changed_r <= 1'b1;
          end
        end
      end
    end
  end

  // Query context
  always_ff @(posedge clk) begin
    if (acc_qry) begin
      q_vertex_r  <= in_chan.query_vertex;
      q_inrange_r <= 32'(in_chan.query_vertex) < 32'(MAX_VERTICES);
    end
  end

  // Output beat register
  logic q_ok;
  assign q_ok = ran_r && q_inrange_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RES && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_QRY && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RES && slot_free) begin
      o_neg_r    <= neg_r;
      o_ovf_r    <= ovf_r;
      o_passes_r <= (passes_r > VCOUNT_W'(255)) ? 8'hFF : passes_r[PASS_OUT_W-1:0];
      o_vecho_r  <= '0;
      o_reach_r  <= 1'b0;
      o_dist_r   <= '0;
      o_hp_r     <= 1'b0;
      o_par_r    <= '0;
    end else if (state_r == S_QRY && slot_free) begin
      o_neg_r    <= 1'b0;
      o_ovf_r    <= 1'b0;
      o_passes_r <= '0;
      o_vecho_r  <= q_vertex_r;
      o_reach_r  <= q_ok && (rd_a_r[DIST_W-1:0] != DIST_INF);
      o_dist_r   <= q_ok ? rd_a_r[DIST_W-1:0] : DIST_INF;
      o_hp_r     <= q_ok && rd_a_r[DMW-1];
      o_par_r    <= (q_ok && rd_a_r[DMW-1]) ? rd_a_r[DMW-2:DIST_W] : '0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.negative_cycle = o_neg_r;
  assign out_chan.edge_overflow  = o_ovf_r;
  assign out_chan.passes_used    = o_passes_r;
  assign out_chan.vertex_echo    = o_vecho_r;
  assign out_chan.reachable      = o_reach_r;
  assign out_chan.distance       = o_dist_r;
  assign out_chan.has_parent     = o_hp_r;
  assign out_chan.parent_vertex  = o_par_r;

endmodule
`default_nettype wire

// ===== rtl/sssp_relax.sv =====
`default_nettype none
module sssp_relax (
  input  logic [sssp_pkg::VID_W-1:0]    u,
  input  logic [sssp_pkg::VID_W-1:0]    v,
  input  logic [sssp_pkg::VCOUNT_W-1:0] n,
  input  logic [sssp_pkg::DIST_W-1:0]   du,
  input  logic [sssp_pkg::DIST_W-1:0]   dv,
  input  logic [sssp_pkg::DIST_W-1:0]   w,
  output sssp_pkg::relax_t              res
);
  import sssp_pkg::*;

  logic [DIST_W:0] sum;
  logic            ends_ok;

  // Both endpoints inside the active graph
  assign ends_ok = ({1'b0, u} < n) && ({1'b0, v} < n);

  // Carry out of the add means the path length would pass the 32-bit maximum
  assign sum = {1'b0, du} + {1'b0, w};

  always_comb begin
    res.alt = sum[DIST_W-1:0];
    res.hit = ends_ok && (du != DIST_INF) && !sum[DIST_W] && (sum[DIST_W-1:0] < dv);
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_single_source_shortest_path_core.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_single_source_shortest_path_core;
  import sssp_pkg::*;

  localparam int NV        = MAX_VERTICES_DEF;
  localparam int NE        = MAX_EDGES_DEF;
  localparam int ITEMS     = 1200;
  localparam int MAX_CYCLE = 4_000_000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VID_W-1:0]  edge_source;
    logic [VID_W-1:0]  edge_dest;
    logic [DIST_W-1:0] edge_weight;
    logic [VID_W-1:0]  query_vertex;
  } command_t;

  typedef struct packed {
    logic                  negative_cycle;
    logic                  edge_overflow;
    logic [PASS_OUT_W-1:0] passes_used;
    logic [VID_W-1:0]      vertex_echo;
    logic                  reachable;
    logic [DIST_W-1:0]     distance;
    logic                  has_parent;
    logic [VID_W-1:0]      parent_vertex;
  } answer_t;

  // Mirror of the solver: edge list, distance/parent tables and the two registers
  class shortest_path_scoreboard;
    logic [VID_W-1:0]    edge_src [NE];
    logic [VID_W-1:0]    edge_dst [NE];
    logic [DIST_W-1:0]   edge_wt [NE];
    int                  edge_total;
    bit                  overflow_seen;
    logic [DIST_W-1:0]   dist_tab [NV];
    logic [VID_W-1:0]    parent [NV];
    bit                  parent_ok [NV];
    logic [VCOUNT_W-1:0] vertex_count;
    logic [VID_W-1:0]    root_vertex;
    answer_t             pending [$];
    int                  errors;

    function new();
      for (int i = 0; i < NV; i++) begin
        dist_tab[i]  = DIST_INF;
        parent[i]    = '0;
        parent_ok[i] = 1'b0;
      end
      edge_total    = 0;
      overflow_seen = 1'b0;
      vertex_count  = 9'd256;
      root_vertex   = '0;
      errors        = 0;
    endfunction

    // 0 behaves as 1, anything above the table size as the table size
    function int active_count();
      if (vertex_count < 1) return 1;
      if (vertex_count > NV) return NV;
      return int'(vertex_count);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_VERTEX_COUNT) vertex_count = data;
      else root_vertex = data[VID_W-1:0];
    endfunction

    // One relaxation test; writes the tables only when apply is set
    function bit try_relax(int k, int n, bit apply);
      logic [VID_W-1:0]  u;
      logic [VID_W-1:0]  v;
      logic [DIST_W-1:0] w;
      logic [DIST_W-1:0] du;
      logic [DIST_W-1:0] alt;
      u = edge_src[k];
      v = edge_dst[k];
      w = edge_wt[k];
      if (int'(u) >= n || int'(v) >= n) return 1'b0;
      du = dist_tab[u];
      if (du == DIST_INF) return 1'b0;
      if (du > DIST_INF - w) return 1'b0;
      alt = du + w;
      if (alt >= dist_tab[v]) return 1'b0;
      if (apply) begin
        dist_tab[v]  = alt;
        parent[v]    = u;
        parent_ok[v] = 1'b1;
      end
      return 1'b1;
    endfunction

    function answer_t solve_paths();
      answer_t a;
      int      n;
      int      passes;
      bit      changed;
      bit      neg;
      a      = '0;
      n      = active_count();
      passes = 0;
      neg    = 1'b0;
      for (int i = 0; i < NV; i++) begin
        dist_tab[i]  = DIST_INF;
        parent_ok[i] = 1'b0;
      end
      if (int'(root_vertex) < n) dist_tab[root_vertex] = '0;
      for (int i = 1; i < n; i++) begin
        changed = 1'b0;
        passes++;
        for (int k = 0; k < edge_total; k++) begin
          if (try_relax(k, n, 1'b1)) changed = 1'b1;
        end
        if (!changed) break;
      end
      // check pass, no write back
      for (int k = 0; k < edge_total; k++) begin
        if (try_relax(k, n, 1'b0)) begin
          neg = 1'b1;
          break;
        end
      end
      a.negative_cycle = neg;
      a.edge_overflow  = overflow_seen;
      a.passes_used    = (passes > 255) ? 8'd255 : passes[7:0];
      return a;
    endfunction

    function answer_t answer_query(logic [VID_W-1:0] q);
      answer_t a;
      a               = '0;
      a.vertex_echo   = q;
      a.distance      = dist_tab[q];
      a.reachable     = (dist_tab[q] != DIST_INF);
      a.has_parent    = parent_ok[q];
      a.parent_vertex = parent_ok[q] ? parent[q] : '0;
      return a;
    endfunction

    // Called on every accepted input beat
    function void note_command(command_t c);
      case (c.kind)
        KIND_ADD: begin
          if (edge_total >= NE) begin
            overflow_seen = 1'b1;
          end else begin
            edge_src[edge_total] = c.edge_source;
            edge_dst[edge_total] = c.edge_dest;
            edge_wt[edge_total]  = c.edge_weight;
            edge_total++;
          end
        end
        KIND_CLEAR: begin
          edge_total    = 0;
          overflow_seen = 1'b0;
        end
        KIND_RUN: pending.push_back(solve_paths());
        default: pending.push_back(answer_query(c.query_vertex));
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Called on every accepted result beat
    function void check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        $error("result beat with no run or query outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("negative_cycle", want.negative_cycle, got.negative_cycle);
      check_field("edge_overflow", want.edge_overflow, got.edge_overflow);
      check_field("passes_used", want.passes_used, got.passes_used);
      check_field("vertex_echo", want.vertex_echo, got.vertex_echo);
      check_field("reachable", want.reachable, got.reachable);
      check_field("distance", want.distance, got.distance);
      check_field("has_parent", want.has_parent, got.has_parent);
      check_field("parent_vertex", want.parent_vertex, got.parent_vertex);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sssp_in_if  in_bus ();
  sssp_out_if out_bus ();

  shortest_path_scoreboard sb = new();

  bit no_gaps;
  int items_sent;
  int cycles;

  single_source_shortest_path_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short idles, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIST_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 100);
    if (r < 75) return $urandom & 32'h7FFF_FFFF;
    if (r < 85) return 32'h8000_0000;
    if (r < 95) return $urandom_range(32'h7FFF_F000, 32'h7FFF_FFFF);
    return '0;
  endfunction

  // Mostly inside the active range, sometimes anywhere
  function automatic logic [VID_W-1:0] pick_vertex(int n);
    if ($urandom_range(0, 99) < 85) return VID_W'($urandom_range(0, n - 1));
    return VID_W'($urandom_range(0, 255));
  endfunction

  // Unused fields carry random junk
  function automatic command_t noise_command(logic [KIND_W-1:0] kind);
    command_t c;
    c.kind         = kind;
    c.edge_source  = VID_W'($urandom_range(0, 255));
    c.edge_dest    = VID_W'($urandom_range(0, 255));
    c.edge_weight  = $urandom & 32'h7FFF_FFFF;
    c.query_vertex = VID_W'($urandom_range(0, 255));
    return c;
  endfunction

  // Result side: random stalls on ready
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    answer_t got;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.negative_cycle = out_bus.negative_cycle;
      got.edge_overflow  = out_bus.edge_overflow;
      got.passes_used    = out_bus.passes_used;
      got.vertex_echo    = out_bus.vertex_echo;
      got.reachable      = out_bus.reachable;
      got.distance       = out_bus.distance;
      got.has_parent     = out_bus.has_parent;
      got.parent_vertex  = out_bus.parent_vertex;
      sb.check_answer(got);
    end
  end

  // Drive one input beat; valid stays high afterwards unless a gap follows
  task automatic issue(command_t c);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= c.kind;
    in_bus.edge_source  <= c.edge_source;
    in_bus.edge_dest    <= c.edge_dest;
    in_bus.edge_weight  <= c.edge_weight;
    in_bus.query_vertex <= c.query_vertex;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_command(c);
    items_sent++;
  endtask

  task automatic add_edge(logic [VID_W-1:0] src, logic [VID_W-1:0] dst,
                          logic [DIST_W-1:0] w);
    command_t c;
    c             = noise_command(KIND_ADD);
    c.edge_source = src;
    c.edge_dest   = dst;
    c.edge_weight = w;
    issue(c);
  endtask

  task automatic send_op(logic [KIND_W-1:0] kind);
    issue(noise_command(kind));
  endtask

  task automatic ask(logic [VID_W-1:0] q);
    command_t c;
    c              = noise_command(KIND_QUERY);
    c.query_vertex = q;
    issue(c);
  endtask

  // Wait until every answer is back and the block has gone quiet
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(bit wr_count, logic [VCOUNT_W-1:0] new_count,
                            bit wr_start, logic [VID_W-1:0] new_start);
    if (wr_count) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_VERTEX_COUNT;
      cfg_wdata <= new_count;
      @(posedge clk);
      sb.set_register(CFG_VERTEX_COUNT, new_count);
    end
    if (wr_start) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_ROOT_VERTEX;
      cfg_wdata <= {1'b0, new_start};
      @(posedge clk);
      sb.set_register(CFG_ROOT_VERTEX, {1'b0, new_start});
    end
    cfg_we <= 1'b0;
  endtask

  // Fill the store past capacity with a small graph so runs stay short
  task automatic flood_edge_store();
    settle();
    set_config(1'b1, 9'd4, 1'b1, 8'd0);
    send_op(KIND_CLEAR);
    repeat (NE + 6) add_edge(pick_vertex(4), pick_vertex(4), pick_weight());
    send_op(KIND_RUN);
    for (int q = 0; q < 4; q++) ask(VID_W'(q));
    add_edge(0, 1, 1);
    send_op(KIND_RUN);
    send_op(KIND_CLEAR);
    send_op(KIND_RUN);
    ask(1);
  endtask

  // Chain loaded back to front: one new vertex per pass, full pass count
  task automatic walk_long_chain();
    settle();
    set_config(1'b1, 9'd256, 1'b1, 8'd0);
    send_op(KIND_CLEAR);
    for (int i = NV - 2; i >= 0; i--)
      add_edge(VID_W'(i), VID_W'(i + 1), DIST_W'($urandom_range(0, 1000)));
    send_op(KIND_RUN);
    ask(255);
    ask(128);
    ask(1);
    send_op(KIND_CLEAR);
  endtask

  task automatic run_phase();
    int r;
    int n_val;
    int n_eff;
    no_gaps = ($urandom_range(0, 3) == 0);
    settle();
    // new register settings most of the time
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      if (r < 55) n_val = $urandom_range(2, 12);
      else if (r < 65) n_val = 256;
      else if (r < 70) n_val = 1;
      else if (r < 75) n_val = 0;
      else if (r < 82) n_val = $urandom_range(257, 511);
      else n_val = $urandom_range(13, 255);
      n_eff = (n_val < 1) ? 1 : (n_val > NV) ? NV : n_val;
      r = $urandom_range(0, 99);
      if (r < 75)
        set_config(1'b1, VCOUNT_W'(n_val), 1'b1, VID_W'($urandom_range(0, n_eff - 1)));
      else if (r < 85) set_config(1'b1, VCOUNT_W'(n_val), 1'b1, 8'd255);
      else if (r < 92) set_config(1'b1, VCOUNT_W'(n_val), 1'b1, 8'd0);
      else set_config(1'b1, VCOUNT_W'(n_val), 1'b1, VID_W'($urandom_range(0, 255)));
    end
    n_eff = sb.active_count();
    if (sb.edge_total > 100) send_op(KIND_CLEAR);
    if ($urandom_range(0, 99) < 15) begin
      // noise: any kind in any order
      repeat (12) begin
        case ($urandom_range(0, 3))
          KIND_ADD: add_edge(pick_vertex(n_eff), pick_vertex(n_eff), pick_weight());
          KIND_RUN: send_op(KIND_RUN);
          KIND_QUERY: ask(pick_vertex(n_eff));
          default: send_op(KIND_CLEAR);
        endcase
      end
    end else begin
      // load a graph, solve it, look at the answers
      if ($urandom_range(0, 4) != 0) send_op(KIND_CLEAR);
      repeat ($urandom_range(0, 30))
        add_edge(pick_vertex(n_eff), pick_vertex(n_eff), pick_weight());
      send_op(KIND_RUN);
      repeat ($urandom_range(2, 8)) ask(pick_vertex(n_eff));
    end
  endtask

  initial begin
    int phase;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_bus.valid        = 1'b0;
    in_bus.kind         = KIND_ADD;
    in_bus.edge_source  = '0;
    in_bus.edge_dest    = '0;
    in_bus.edge_weight  = '0;
    in_bus.query_vertex = '0;
    no_gaps             = 1'b0;
    items_sent          = 0;
    cycles              = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: nothing solved yet
    ask(0);
    ask(255);
    settle();
    set_config(1'b1, 9'd5, 1'b1, 8'd0);
    // sums past the 32-bit max, sum landing on all ones, bad endpoints, self loop
    add_edge(0, 1, 32'h8000_0000);
    add_edge(1, 2, 32'h8000_0000);
    add_edge(0, 3, 32'h7FFF_FFFF);
    add_edge(3, 2, 32'h8000_0000);
    add_edge(0, 4, 32'h0);
    add_edge(4, 9, 32'h1);
    add_edge(200, 4, 32'h0);
    add_edge(4, 4, 32'h0);
    add_edge(4, 3, 32'h0000_FFFF);
    send_op(KIND_RUN);
    for (int q = 0; q < 5; q++) ask(VID_W'(q));
    ask(9);
    // clear keeps distances until the next run
    send_op(KIND_CLEAR);
    ask(3);
    send_op(KIND_RUN);
    ask(3);
    // start outside the graph
    settle();
    set_config(1'b0, 9'd0, 1'b1, 8'd7);
    add_edge(0, 1, 5);
    send_op(KIND_RUN);
    ask(0);
    // zero vertices acts as one
    settle();
    set_config(1'b1, 9'd0, 1'b1, 8'd0);
    send_op(KIND_RUN);
    ask(0);

    // Random phases, with the store flood and the long chain mixed in
    phase = 0;
    while (items_sent < ITEMS || phase <= 5) begin
      if (phase == 2) flood_edge_store();
      else if (phase == 5) walk_long_chain();
      else run_phase();
      phase++;
    end

    settle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/sssp_pkg.sv
rtl/sssp_in_if.sv
rtl/sssp_out_if.sv
rtl/sssp_relax.sv
rtl/single_source_shortest_path_core.sv
tb/sv/tb_single_source_shortest_path_core.sv
